// File: hw/rtl/kd_sah_split_finder_macros.svh
// Assertion macros used by the split finder checker.
`ifndef KD_SAH_SPLIT_FINDER_MACROS_SVH
`define KD_SAH_SPLIT_FINDER_MACROS_SVH
// same-cycle implication
`define KSF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define KSF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: hw/rtl/ksf_pkg.sv
// Types and constants of the kd-tree SAH split finder.
package ksf_pkg;

   localparam int AXES = 3;

   localparam logic [1:0] REG_TRAVERSE = 2'd0;
   localparam logic [1:0] REG_INTERSECT = 2'd1;
   localparam logic [1:0] REG_MAX_DEPTH = 2'd2;
   localparam logic [1:0] REG_MIN_LEAF = 2'd3;

   typedef struct packed {
      logic [7:0] traverse_cost;
      logic [7:0] intersect_cost;
      logic [5:0] max_depth;
      logic [8:0] min_leaf;
   } cfg_type;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ADD
   } mac_mode_type;

   typedef struct packed {
      mac_mode_type mode;
      logic         shift;
   } mac_ctl_type;

   typedef enum logic [5:0] {
      SEQ_IDLE, SEQ_CHK,
      SEQ_NA0, SEQ_NA1, SEQ_NA2, SEQ_NK, SEQ_NKC, SEQ_NM0, SEQ_NM1, SEQ_NB,
      SEQ_MIN, SEQ_CNT,
      SEQ_L0, SEQ_L1, SEQ_L2, SEQ_R0, SEQ_R1, SEQ_R2,
      SEQ_K1, SEQ_K2, SEQ_K3, SEQ_K4,
      SEQ_SL0, SEQ_SL1, SEQ_SL2, SEQ_SL3,
      SEQ_SR0, SEQ_SR1, SEQ_SR2, SEQ_SR3,
      SEQ_CMP, SEQ_UPD, SEQ_DONE
   } state_type;

endpackage

// File: hw/rtl/kd_sah_split_finder.sv
// kd-tree SAH split finder: member loader, sequencer and search datapath.
// Usage: words enter on req_* when start is high and busy low. An op 0
// word loads the node box and depth and empties the member store; op 1
// words append member boxes, one per cycle while busy is low, into a RAM
// of MAX_MEMBERS entries. A word with req_last set starts the search;
// busy stays high until the result word is shown on rsp_* for exactly
// one cycle with rsp_valid. A search that stops on the depth or leaf
// limit answers without any pass. Otherwise it runs setup, then per axis
// one min pass over the members and per distinct bound one count pass
// over the members plus cost evaluation through the single shared
// multiply-accumulate unit. The member RAM read port sets the pass length;
// the shared multiplier sets the cost step.
// Reset: registers return to 1, 1, 20, 1; member count, node box, depth and
// overflow flag clear; RAM contents are not cleared.
// The receiver cannot stall: the result word must be taken when shown.
// The user must write configuration over APB only while busy is low; the block does not enforce it.
module kd_sah_split_finder import ksf_pkg::*; #(
   parameter int MAX_MEMBERS = 256,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [15:0] req_min_x,
   input  logic [15:0] req_min_y,
   input  logic [15:0] req_min_z,
   input  logic [15:0] req_max_x,
   input  logic [15:0] req_max_y,
   input  logic [15:0] req_max_z,
   input  logic [5:0]  req_node_depth,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic        rsp_split_found,
   output logic [1:0]  rsp_split_axis,
   output logic [15:0] rsp_split_point,
   output logic        rsp_planar_to_left,
   output logic [8:0]  rsp_left_count,
   output logic [8:0]  rsp_right_count,
   output logic [8:0]  rsp_planar_count,
   output logic        rsp_overflowed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int CB = COORD_BITS;
   localparam int EW = CB + 1;
   localparam int AW = 2 * EW + 2;
   localparam int NB = $clog2(MAX_MEMBERS + 1);
   localparam int AB = $clog2(MAX_MEMBERS);
   localparam int KW = 8 + NB;
   localparam int LW = (AW + 1) / 2;
   localparam int HW = AW - LW;
   localparam int M0 = (EW > LW + 1) ? EW : LW + 1;
   localparam int M1 = (HW > KW + 1) ? HW : KW + 1;
   localparam int MW = (M0 > M1) ? M0 : M1;
   localparam int ACCW = 2 * MW + LW + 2;
   localparam int CW = ACCW + 1;
   localparam int DW = 6 * CB;
   localparam int LMW = (NB > 9) ? NB : 9;

   cfg_type cfg;
   state_type state_ff, state_in;

   logic [CB-1:0] node_lo_ff [AXES], node_lo_in [AXES];
   logic [CB-1:0] node_hi_ff [AXES], node_hi_in [AXES];
   logic [5:0]    level_ff, level_in;
   logic [NB-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;

   logic          accept;
   logic          wr_en;
   logic [DW-1:0] wr_data;
   logic [AB-1:0] rd_addr;
   logic [DW-1:0] rd_data;

   logic [NB-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   logic          issue;

   logic [1:0]    ax_ff, ax_in;
   logic [CB-1:0] v_ff, v_in;
   logic [CB-1:0] mn_ff, mn_in;
   logic [CB-1:0] nx_ff, nx_in;
   logic          have_ff, have_in;
   logic [NB-1:0] tl_ff, tl_in, tr_ff, tr_in, tp_ff, tp_in;

   logic [AW-1:0] la_ff, la_in, ra_ff, ra_in;
   logic [KW-1:0] k1_ff, k1_in, k2_ff, k2_in, k3_ff, k3_in, k4_ff, k4_in;
   logic signed [ACCW-1:0] sl_ff, sl_in;
   logic signed [CW-1:0]   cost_ff, cost_in, best_ff, best_in;
   logic                   cleft_ff, cleft_in;

   logic          found_ff, found_in, bleft_ff, bleft_in;
   logic [1:0]    bax_ff, bax_in;
   logic [CB-1:0] bpt_ff, bpt_in;
   logic [NB-1:0] bl_ff, bl_in, br_ff, br_in, bp_ff, bp_in;

   logic          rsp_valid_ff, rsp_valid_in;

   mac_ctl_type           mac_ctl;
   logic signed [MW-1:0]  opa, opb;
   logic signed [ACCW-1:0] acc;

   logic signed [EW-1:0] ext [AXES];
   logic signed [EW-1:0] eb, ec, lside, rside;
   logic [CB-1:0]        nlo, nhi, mlo, mhi, m1, m2, nx1;
   logic                 hv1;
   logic signed [MW-1:0] la_lo, la_hi, ra_lo, ra_hi;
   logic signed [MW-1:0] k1s, k2s, k3s, k4s;
   logic signed [ACCW-1:0] pick;
   logic                  skip;

   ksf_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .cfg(cfg)
   );

   ksf_ram #(.WIDTH(DW), .DEPTH(MAX_MEMBERS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AB-1:0]),
      .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   ksf_mac #(.MW(MW), .ACCW(ACCW), .SH(LW)) u_mac (
      .clock(clock), .ctl(mac_ctl), .opa(opa), .opb(opb), .acc(acc)
   );

   assign busy = (state_ff != SEQ_IDLE);
   assign accept = start && !busy;
   assign wr_en = accept && req_op && (count_ff < NB'(MAX_MEMBERS));
   assign wr_data = {CB'(req_max_z), CB'(req_max_y), CB'(req_max_x),
                     CB'(req_min_z), CB'(req_min_y), CB'(req_min_x)};

   // node and member loading
   always_comb begin
      node_lo_in = node_lo_ff;
      node_hi_in = node_hi_ff;
      level_in = level_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (!req_op) begin
            node_lo_in[0] = CB'(req_min_x);
            node_lo_in[1] = CB'(req_min_y);
            node_lo_in[2] = CB'(req_min_z);
            node_hi_in[0] = CB'(req_max_x);
            node_hi_in[1] = CB'(req_max_y);
            node_hi_in[2] = CB'(req_max_z);
            level_in = req_node_depth;
            count_in = '0;
            ovf_in = 1'b0;
         end else if (wr_en) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // per-axis operands
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         ext[i] = $signed({1'b0, node_hi_ff[i]}) - $signed({1'b0, node_lo_ff[i]});
      end
      case (ax_ff)
         2'd1: begin
            eb = ext[0]; ec = ext[2];
            nlo = node_lo_ff[1]; nhi = node_hi_ff[1];
            mlo = rd_data[CB +: CB]; mhi = rd_data[4*CB +: CB];
         end
         2'd2: begin
            eb = ext[0]; ec = ext[1];
            nlo = node_lo_ff[2]; nhi = node_hi_ff[2];
            mlo = rd_data[2*CB +: CB]; mhi = rd_data[5*CB +: CB];
         end
         default: begin
            eb = ext[1]; ec = ext[2];
            nlo = node_lo_ff[0]; nhi = node_hi_ff[0];
            mlo = rd_data[0 +: CB]; mhi = rd_data[3*CB +: CB];
         end
      endcase
      lside = $signed({1'b0, v_ff}) - $signed({1'b0, nlo});
      rside = $signed({1'b0, nhi}) - $signed({1'b0, v_ff});
      la_lo = MW'($signed({1'b0, la_ff[LW-1:0]}));
      la_hi = MW'($signed(la_ff[AW-1:LW]));
      ra_lo = MW'($signed({1'b0, ra_ff[LW-1:0]}));
      ra_hi = MW'($signed(ra_ff[AW-1:LW]));
      k1s = MW'($signed({1'b0, k1_ff}));
      k2s = MW'($signed({1'b0, k2_ff}));
      k3s = MW'($signed({1'b0, k3_ff}));
      k4s = MW'($signed({1'b0, k4_ff}));
      m1 = (mlo < mn_ff) ? mlo : mn_ff;
      m2 = (mhi < m1) ? mhi : m1;
      nx1 = nx_ff;
      hv1 = have_ff;
      if (mlo > v_ff && (!hv1 || mlo < nx1)) begin
         nx1 = mlo;
         hv1 = 1'b1;
      end
      pick = (sl_ff < acc) ? sl_ff : acc;
      skip = (level_ff >= cfg.max_depth) ||
             (LMW'(count_ff) <= LMW'(cfg.min_leaf));
   end

   assign issue = (cnt_ff < count_ff);
   assign rd_addr = cnt_ff[AB-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      mac_ctl = '{mode: MAC_HOLD, shift: 1'b0};
      opa = '0;
      opb = '0;
      cnt_in = '0;
      rv_in = 1'b0;
      ax_in = ax_ff;
      v_in = v_ff;
      mn_in = '1;
      nx_in = nx_ff;
      have_in = have_ff;
      tl_in = tl_ff;
      tr_in = tr_ff;
      tp_in = tp_ff;
      la_in = la_ff;
      ra_in = ra_ff;
      k1_in = k1_ff;
      k2_in = k2_ff;
      k3_in = k3_ff;
      k4_in = k4_ff;
      sl_in = sl_ff;
      cost_in = cost_ff;
      cleft_in = cleft_ff;
      best_in = best_ff;
      found_in = found_ff;
      bleft_in = bleft_ff;
      bax_in = bax_ff;
      bpt_in = bpt_ff;
      bl_in = bl_ff;
      br_in = br_ff;
      bp_in = bp_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept && req_last) begin
               state_in = SEQ_CHK;
            end
         end
         SEQ_CHK: begin
            found_in = 1'b0;
            bleft_in = 1'b0;
            bax_in = '0;
            bpt_in = '0;
            bl_in = '0;
            br_in = '0;
            bp_in = '0;
            state_in = skip ? SEQ_DONE : SEQ_NA0;
         end
         SEQ_NA0: begin
            mac_ctl.mode = MAC_LOAD;
            opa = MW'(ext[0]);
            opb = MW'(ext[1]);
            state_in = SEQ_NA1;
         end
         SEQ_NA1: begin
            mac_ctl.mode = MAC_ADD;
            opa = MW'(ext[0]);
            opb = MW'(ext[2]);
            state_in = SEQ_NA2;
         end
         SEQ_NA2: begin
            mac_ctl.mode = MAC_ADD;
            opa = MW'(ext[1]);
            opb = MW'(ext[2]);
            state_in = SEQ_NK;
         end
         SEQ_NK: begin
            la_in = AW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = MW'($signed({1'b0, cfg.intersect_cost}));
            opb = MW'($signed({1'b0, count_ff}));
            state_in = SEQ_NKC;
         end
         SEQ_NKC: begin
            k1_in = KW'(acc);
            state_in = SEQ_NM0;
         end
         SEQ_NM0: begin
            mac_ctl.mode = MAC_LOAD;
            opa = la_lo;
            opb = k1s;
            state_in = SEQ_NM1;
         end
         SEQ_NM1: begin
            mac_ctl = '{mode: MAC_ADD, shift: 1'b1};
            opa = la_hi;
            opb = k1s;
            state_in = SEQ_NB;
         end
         SEQ_NB: begin
            best_in = CW'(acc);
            ax_in = '0;
            state_in = SEQ_MIN;
         end
         SEQ_MIN: begin
            cnt_in = issue ? cnt_ff + 1'b1 : cnt_ff;
            rv_in = issue;
            mn_in = rv_ff ? m2 : mn_ff;
            tl_in = '0;
            tr_in = count_ff;
            tp_in = '0;
            have_in = 1'b0;
            if (!issue && !rv_ff) begin
               v_in = mn_ff;
               cnt_in = '0;
               state_in = SEQ_CNT;
            end
         end
         SEQ_CNT: begin
            cnt_in = issue ? cnt_ff + 1'b1 : cnt_ff;
            rv_in = issue;
            if (rv_ff) begin
               if (mlo == mhi) begin
                  tl_in = tl_ff + NB'(mlo < v_ff);
                  tr_in = tr_ff - NB'(mlo <= v_ff);
                  tp_in = tp_ff + NB'(mlo == v_ff);
               end else begin
                  tl_in = tl_ff + NB'(mlo <= v_ff);
                  tr_in = tr_ff - NB'(mhi <= v_ff);
               end
               nx_in = nx1;
               have_in = hv1;
               if (mhi > v_ff && (!hv1 || mhi < nx1)) begin
                  nx_in = mhi;
                  have_in = 1'b1;
               end
            end
            if (!issue && !rv_ff) begin
               state_in = SEQ_L0;
            end
         end
         SEQ_L0: begin
            mac_ctl.mode = MAC_LOAD;
            opa = MW'(lside);
            opb = MW'(eb);
            state_in = SEQ_L1;
         end
         SEQ_L1: begin
            mac_ctl.mode = MAC_ADD;
            opa = MW'(lside);
            opb = MW'(ec);
            state_in = SEQ_L2;
         end
         SEQ_L2: begin
            mac_ctl.mode = MAC_ADD;
            opa = MW'(eb);
            opb = MW'(ec);
            state_in = SEQ_R0;
         end
         SEQ_R0: begin
            la_in = AW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = MW'(rside);
            opb = MW'(eb);
            state_in = SEQ_R1;
         end
         SEQ_R1: begin
            mac_ctl.mode = MAC_ADD;
            opa = MW'(rside);
            opb = MW'(ec);
            state_in = SEQ_R2;
         end
         SEQ_R2: begin
            mac_ctl.mode = MAC_ADD;
            opa = MW'(eb);
            opb = MW'(ec);
            state_in = SEQ_K1;
         end
         SEQ_K1: begin
            ra_in = AW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = MW'($signed({1'b0, cfg.intersect_cost}));
            opb = MW'($signed({1'b0, tl_ff + tp_ff}));
            state_in = SEQ_K2;
         end
         SEQ_K2: begin
            k1_in = KW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = MW'($signed({1'b0, cfg.intersect_cost}));
            opb = MW'($signed({1'b0, tr_ff}));
            state_in = SEQ_K3;
         end
         SEQ_K3: begin
            k2_in = KW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = MW'($signed({1'b0, cfg.intersect_cost}));
            opb = MW'($signed({1'b0, tl_ff}));
            state_in = SEQ_K4;
         end
         SEQ_K4: begin
            k3_in = KW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = MW'($signed({1'b0, cfg.intersect_cost}));
            opb = MW'($signed({1'b0, tr_ff + tp_ff}));
            state_in = SEQ_SL0;
         end
         SEQ_SL0: begin
            k4_in = KW'(acc);
            mac_ctl.mode = MAC_LOAD;
            opa = la_lo;
            opb = k1s;
            state_in = SEQ_SL1;
         end
         SEQ_SL1: begin
            mac_ctl = '{mode: MAC_ADD, shift: 1'b1};
            opa = la_hi;
            opb = k1s;
            state_in = SEQ_SL2;
         end
         SEQ_SL2: begin
            mac_ctl.mode = MAC_ADD;
            opa = ra_lo;
            opb = k2s;
            state_in = SEQ_SL3;
         end
         SEQ_SL3: begin
            mac_ctl = '{mode: MAC_ADD, shift: 1'b1};
            opa = ra_hi;
            opb = k2s;
            state_in = SEQ_SR0;
         end
         SEQ_SR0: begin
            sl_in = acc;
            mac_ctl.mode = MAC_LOAD;
            opa = la_lo;
            opb = k3s;
            state_in = SEQ_SR1;
         end
         SEQ_SR1: begin
            mac_ctl = '{mode: MAC_ADD, shift: 1'b1};
            opa = la_hi;
            opb = k3s;
            state_in = SEQ_SR2;
         end
         SEQ_SR2: begin
            mac_ctl.mode = MAC_ADD;
            opa = ra_lo;
            opb = k4s;
            state_in = SEQ_SR3;
         end
         SEQ_SR3: begin
            mac_ctl = '{mode: MAC_ADD, shift: 1'b1};
            opa = ra_hi;
            opb = k4s;
            state_in = SEQ_CMP;
         end
         SEQ_CMP: begin
            cleft_in = (sl_ff < acc);
            cost_in = CW'($signed({1'b0, cfg.traverse_cost})) + CW'(pick);
            state_in = SEQ_UPD;
         end
         SEQ_UPD: begin
            if (cost_ff < best_ff) begin
               best_in = cost_ff;
               found_in = 1'b1;
               bleft_in = cleft_ff;
               bax_in = ax_ff;
               bpt_in = v_ff;
               bl_in = tl_ff;
               br_in = tr_ff;
               bp_in = tp_ff;
            end
            tl_in = '0;
            tr_in = count_ff;
            tp_in = '0;
            have_in = 1'b0;
            if (have_ff) begin
               v_in = nx_ff;
               state_in = SEQ_CNT;
            end else if (ax_ff == 2'd2) begin
               state_in = SEQ_DONE;
            end else begin
               ax_in = ax_ff + 1'b1;
               state_in = SEQ_MIN;
            end
         end
         SEQ_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         for (int i = 0; i < AXES; i++) begin
            node_lo_ff[i] <= '0;
            node_hi_ff[i] <= '0;
         end
         level_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_lo_ff <= node_lo_in;
         node_hi_ff <= node_hi_in;
         level_ff <= level_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      v_ff <= v_in;
      mn_ff <= mn_in;
      nx_ff <= nx_in;
      have_ff <= have_in;
      tl_ff <= tl_in;
      tr_ff <= tr_in;
      tp_ff <= tp_in;
      la_ff <= la_in;
      ra_ff <= ra_in;
      k1_ff <= k1_in;
      k2_ff <= k2_in;
      k3_ff <= k3_in;
      k4_ff <= k4_in;
      sl_ff <= sl_in;
      cost_ff <= cost_in;
      cleft_ff <= cleft_in;
      best_ff <= best_in;
      found_ff <= found_in;
      bleft_ff <= bleft_in;
      bax_ff <= bax_in;
      bpt_ff <= bpt_in;
      bl_ff <= bl_in;
      br_ff <= br_in;
      bp_ff <= bp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_split_found = found_ff;
   assign rsp_split_axis = bax_ff;
   assign rsp_split_point = 16'(bpt_ff);
   assign rsp_planar_to_left = bleft_ff;
   assign rsp_left_count = 9'(bl_ff);
   assign rsp_right_count = 9'(br_ff);
   assign rsp_planar_count = 9'(bp_ff);
   assign rsp_overflowed = ovf_ff;
endmodule

// File: hw/rtl/ksf_ram.sv
// Generic single-port-write RAM with registered read.
module ksf_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/ksf_csr.sv
// APB configuration registers of the split finder.
module ksf_csr import ksf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);
   cfg_type cfg_ff, cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{traverse_cost: 8'd1, intersect_cost: 8'd1,
                     max_depth: 6'd20, min_leaf: 9'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_TRAVERSE: cfg_in.traverse_cost = pwdata[7:0];
            REG_INTERSECT: cfg_in.intersect_cost = pwdata[7:0];
            REG_MAX_DEPTH: cfg_in.max_depth = pwdata[5:0];
            REG_MIN_LEAF: cfg_in.min_leaf = pwdata[8:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TRAVERSE: prdata = {24'd0, cfg_ff.traverse_cost};
         REG_INTERSECT: prdata = {24'd0, cfg_ff.intersect_cost};
         REG_MAX_DEPTH: prdata = {26'd0, cfg_ff.max_depth};
         REG_MIN_LEAF: prdata = {23'd0, cfg_ff.min_leaf};
         default: prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg = cfg_ff;
endmodule

// File: hw/rtl/ksf_mac.sv
// Shared signed multiply-accumulate unit.
module ksf_mac import ksf_pkg::*; #(
   parameter int MW = 24,
   parameter int ACCW = 64,
   parameter int SH = 12
) (
   input  logic                   clock,
   input  mac_ctl_type            ctl,
   input  logic signed [MW-1:0]   opa,
   input  logic signed [MW-1:0]   opb,
   output logic signed [ACCW-1:0] acc
);
   logic signed [2*MW-1:0] prod;
   logic signed [ACCW-1:0] term;
   logic signed [ACCW-1:0] acc_ff, acc_in;

   assign prod = opa * opb;

   always_comb begin
      term = ACCW'(prod);
      if (ctl.shift) begin
         term = term <<< SH;
      end
      case (ctl.mode)
         MAC_LOAD: acc_in = term;
         MAC_ADD: acc_in = acc_ff + term;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// File: hw/rtl/ksf_chk.sv
// Port-level checker of the split finder and its bind.
`include "kd_sah_split_finder_macros.svh"
module ksf_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_split_found,
   input logic [1:0]  rsp_split_axis,
   input logic [8:0]  rsp_left_count,
   input logic [8:0]  rsp_right_count,
   input logic [8:0]  rsp_planar_count
);
   `KSF_ASSERT_NXT(a_single_pulse, rsp_valid, !rsp_valid, "result word longer than one cycle")
   `KSF_ASSERT_NXT(a_search_busy, start && !busy && req_last, busy, "search did not go busy")
   `KSF_ASSERT_IMP(a_from_busy, rsp_valid, $past(busy), "result word without a search")
   `KSF_ASSERT_IMP(a_no_split_zero, rsp_valid && !rsp_split_found, (rsp_split_axis == 2'd0) && (rsp_left_count == 9'd0) && (rsp_right_count == 9'd0) && (rsp_planar_count == 9'd0), "no-split word not zero")
   `KSF_ASSERT_IMP(a_axis_range, rsp_valid, rsp_split_axis != 2'd3, "axis out of range")
endmodule

bind kd_sah_split_finder ksf_chk u_ksf_chk (.*);
